/* rtl/core/fir8_pkg.sv */
`timescale 1ns / 1ps
package fir8_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int COEF_REGS  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int COEF_UNIT  = 16384;
  localparam int ROUND_HALF = 8192;
  localparam int FRAC_SHIFT = 14;
  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       block_start;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       clipped;
  } out_word_t;

  typedef struct packed {
    logic                       shift;
    logic                       start;
    logic signed [SAMPLE_W-1:0] sample;
  } cell_ctrl_t;

endpackage

/* rtl/core/fir8_tap_cell.sv */
`timescale 1ns / 1ps
module fir8_tap_cell import fir8_pkg::*; #(
  parameter bit HAS_DELAY = 1'b1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cell_ctrl_t                 ctrl_i,
  input  logic signed [SAMPLE_W-1:0] tap_prev_i,
  input  logic signed [COEF_W-1:0]   coef_i,
  output logic signed [SAMPLE_W-1:0] tap_o,
  output logic signed [PROD_W-1:0]   prod_o
);

  logic signed [PROD_W-1:0] prod_q;

  if (HAS_DELAY) begin : g_delay
    logic signed [SAMPLE_W-1:0] held_q;

    // A block start feeds the current sample to the product in place of the held value.
    assign tap_o = ctrl_i.start ? ctrl_i.sample : held_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        held_q <= '0;
      end else if (ctrl_i.shift) begin
        held_q <= tap_prev_i;
      end
    end
  end else begin : g_direct
    assign tap_o = tap_prev_i;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      prod_q <= tap_o * coef_i;
    end
  end

  assign prod_o = prod_q;

endmodule

/* rtl/core/fir8_round_sat.sv */
`timescale 1ns / 1ps
module fir8_round_sat import fir8_pkg::*; #(
  parameter int TAP_COUNT = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic signed [PROD_W-1:0] prod_i [TAP_COUNT],
  input  logic                     valid_i,
  output logic                     ready_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output out_word_t                out_word_o
);

  localparam int ACC_W = PROD_W + $clog2(TAP_COUNT) + 1;

  logic                    sum_valid_q;
  logic                    out_valid_q;
  logic                    sum_en;
  logic                    out_en;
  logic signed [ACC_W-1:0] sum_d;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W:0]   biased;
  logic signed [ACC_W:0]   rounded;
  out_word_t               out_word_d;
  out_word_t               out_word_q;

  assign out_en  = !out_valid_q || out_ready_i;
  assign sum_en  = !sum_valid_q || out_en;
  assign ready_o = sum_en;

  always_comb begin
    sum_d = '0;
    for (int k = 0; k < TAP_COUNT; k++) begin
      sum_d = sum_d + ACC_W'(prod_i[k]);
    end
  end

  always_comb begin
    biased  = {acc_q[ACC_W-1], acc_q} + (ACC_W+1)'(ROUND_HALF);
    rounded = biased >>> FRAC_SHIFT;
    if (rounded > $signed((ACC_W+1)'(SAMPLE_MAX))) begin
      out_word_d.sample_out = SAMPLE_W'(SAMPLE_MAX);
      out_word_d.clipped    = 1'b1;
    end else if (rounded < $signed((ACC_W+1)'(SAMPLE_MIN))) begin
      out_word_d.sample_out = SAMPLE_W'(SAMPLE_MIN);
      out_word_d.clipped    = 1'b1;
    end else begin
      out_word_d.sample_out = rounded[SAMPLE_W-1:0];
      out_word_d.clipped    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (sum_en) begin
        sum_valid_q <= valid_i;
      end
      if (out_en) begin
        out_valid_q <= sum_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_en && valid_i) begin
      acc_q <= sum_d;
    end
    if (out_en && sum_valid_q) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

/* rtl/core/fir_filter_8tap.sv */
// Each tap cell owns one multiplier; a word passes the product, sum and output registers.
// Throughput: one word per cycle while out_ready_i is high; the sum is one stage.
// Reset (asynchronous, active low) clears the delay line and the pipeline valids,
// and sets the coefficients to a unit impulse (coef_0 = 1.0, all others zero).
`timescale 1ns / 1ps
module fir_filter_8tap import fir8_pkg::*; #(
  parameter int TAP_COUNT = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_word_t             in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_word_t            out_word_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COEF_W-1:0]    cfg_data_i
);

  logic signed [COEF_W-1:0]   coef_q [COEF_REGS];
  logic signed [SAMPLE_W-1:0] tap    [TAP_COUNT];
  logic signed [PROD_W-1:0]   prod   [TAP_COUNT];
  logic                       prod_valid_q;
  logic                       post_ready;
  logic                       accept;
  cell_ctrl_t                 ctrl;

  assign in_ready_o = !prod_valid_q || post_ready;
  assign accept     = in_valid_i && in_ready_o;

  assign ctrl.shift  = accept;
  assign ctrl.start  = in_word_i.block_start;
  assign ctrl.sample = in_word_i.sample_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < COEF_REGS; k++) begin
        coef_q[k] <= (k == 0) ? COEF_W'(COEF_UNIT) : '0;
      end
    end else if (cfg_we_i) begin
      coef_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      prod_valid_q <= in_valid_i;
    end
  end

  for (genvar k = 0; k < TAP_COUNT; k++) begin : g_cell
    fir8_tap_cell #(
      .HAS_DELAY (k != 0)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .tap_prev_i ((k == 0) ? in_word_i.sample_in : tap[(k == 0) ? 0 : k - 1]),
      .coef_i     (coef_q[k]),
      .tap_o      (tap[k]),
      .prod_o     (prod[k])
    );
  end

  fir8_round_sat #(
    .TAP_COUNT (TAP_COUNT)
  ) u_round_sat (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .prod_i      (prod),
    .valid_i     (prod_valid_q),
    .ready_o     (post_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule
